// ===== sv/cee_pkg.sv =====
`timescale 1ns / 1ps

package cee_pkg;

    typedef struct packed {
        logic signed [31:0] coef;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] value_at_one;
        logic signed [63:0] value_at_inner;
        logic signed [63:0] slope_at_one;
        logic signed [63:0] slope_at_inner;
        logic               bad_mode;
    } t_out_word;

    typedef enum logic [0:0] {
        CFG_BASIS_MODE  = 1'b0,
        CFG_DERIV_SCALE = 1'b1
    } t_cfg_idx;

    localparam logic [2:0] MODE_FULL    = 3'd0;
    localparam logic [2:0] MODE_COMPACT = 3'd1;
    localparam logic [2:0] MODE_EVEN    = 3'd2;
    localparam logic [2:0] MODE_ODD     = 3'd3;

    localparam logic [2:0]         BASIS_MODE_RST  = MODE_FULL;
    localparam logic signed [31:0] DERIV_SCALE_RST = 32'sd65536;

    // 1/sqrt(2) with 32 fraction bits
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ITEM_MUL2,
        S_ITEM_ADD2,
        S_ITEM_MUL3,
        S_ITEM_ADD3,
        S_FIN_LOAD,
        S_FIN_A0,
        S_FIN_A1,
        S_FIN_RELOAD,
        S_FIN_B0,
        S_FIN_B1,
        S_FIN_B2,
        S_FIN_ROUND,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_ITEM,
        LD_W3,
        LD_BANK,
        LD_PROD
    } t_load;

    typedef struct packed {
        logic       accept;
        t_load      load;
        logic       step;
        logic [1:0] limb;
        logic       add2;
        logic       add3;
        logic       round;
        logic [1:0] sel;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add = s[63:0];
        end
    endfunction

endpackage

// ===== sv/cee_ctrl.sv =====
`timescale 1ns / 1ps

module cee_ctrl
    import cee_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_sel;
    logic [1:0] n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ITEM_MUL2;
                end
            end
            S_ITEM_MUL2:  n_state = S_ITEM_ADD2;
            S_ITEM_ADD2:  n_state = S_ITEM_MUL3;
            S_ITEM_MUL3:  n_state = S_ITEM_ADD3;
            S_ITEM_ADD3:  n_state = i_sts.last ? S_FIN_LOAD : S_IDLE;
            S_FIN_LOAD:   n_state = S_FIN_A0;
            S_FIN_A0:     n_state = S_FIN_A1;
            S_FIN_A1:     n_state = r_sel[1] ? S_FIN_RELOAD : S_FIN_ROUND;
            S_FIN_RELOAD: n_state = S_FIN_B0;
            S_FIN_B0:     n_state = S_FIN_B1;
            S_FIN_B1:     n_state = S_FIN_B2;
            S_FIN_B2:     n_state = S_FIN_ROUND;
            S_FIN_ROUND: begin
                n_sel   = r_sel + 2'd1;
                n_state = (r_sel == 2'd3) ? S_EMIT : S_FIN_LOAD;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.load   = LD_NONE;
        o_cmd.sel    = r_sel;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                o_cmd.load   = i_in_valid ? LD_ITEM : LD_NONE;
            end
            S_ITEM_MUL2: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd0;
            end
            S_ITEM_ADD2: begin
                o_cmd.add2 = 1'b1;
                o_cmd.load = LD_W3;
            end
            S_ITEM_MUL3: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd0;
            end
            S_ITEM_ADD3:  o_cmd.add3 = 1'b1;
            S_FIN_LOAD:   o_cmd.load = LD_BANK;
            S_FIN_A0: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd0;
            end
            S_FIN_A1: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd1;
            end
            S_FIN_RELOAD: o_cmd.load = LD_PROD;
            S_FIN_B0: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd0;
            end
            S_FIN_B1: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd1;
            end
            S_FIN_B2: begin
                o_cmd.step = 1'b1;
                o_cmd.limb = 2'd2;
            end
            S_FIN_ROUND:  o_cmd.round = 1'b1;
            S_EMIT:       o_cmd.emit  = i_sts.out_free;
            default: o_cmd.load = LD_NONE;
        endcase
    end

endmodule

// ===== sv/cee_datapath.sv =====
`timescale 1ns / 1ps

module cee_datapath
    import cee_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  t_in_word           i_in_word,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_deriv_scale,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_out_word          o_out_word
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int SQ_W  = 2 * IDX_W;
    localparam int ODD_W = IDX_W + 1;
    localparam int WGT_W = 2 * IDX_W + 2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TERMS - 1);
    localparam logic [127:0]     HALF_V   = 128'd1 << (FRAC_BITS - 1);
    localparam logic [127:0]     HALF_S   = 128'd1 << (2 * FRAC_BITS - 1);

    logic [IDX_W-1:0]   r_idx;
    logic [SQ_W-1:0]    r_sq;
    logic [ODD_W-1:0]   r_odd;
    logic signed [63:0] r_bank [4];
    logic               r_out_valid;

    logic [2:0]         r_mode;
    logic               r_last;
    logic [95:0]        r_ma;
    logic [31:0]        r_mb;
    logic [127:0]       r_prod;
    logic               r_neg2;
    logic               r_neg3;
    logic               r_negf;
    logic [WGT_W-1:0]   r_w3;
    logic signed [63:0] r_res [4];
    t_out_word          r_out;

    logic               c_neg;
    logic [31:0]        c_mag;
    logic               par;
    logic [WGT_W-1:0]   w_sq;
    logic [WGT_W-1:0]   w_sq4;
    logic [WGT_W-1:0]   w_oddsq;
    logic [WGT_W-1:0]   w2;
    logic [WGT_W-1:0]   w3;
    logic               neg3;
    logic signed [63:0] c64;
    logic signed [63:0] sc;
    logic signed [63:0] term;
    logic signed [63:0] t2;
    logic signed [63:0] t3;
    logic signed [63:0] bsel;
    logic [63:0]        bmag;
    logic [31:0]        ds_mag;
    logic [31:0]        limb;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic [127:0]       rsum;
    logic [127:0]       rq;
    logic               big;
    logic signed [63:0] fin;
    logic               zero;

    assign c_neg = i_in_word.coef[31];
    assign c_mag = c_neg ? (~i_in_word.coef + 32'd1) : i_in_word.coef;
    assign par   = r_idx[0];
    assign c64   = {{32{i_in_word.coef[31]}}, i_in_word.coef};
    assign sc    = par ? -c64 : c64;

    assign w_sq    = WGT_W'(r_sq);
    assign w_sq4   = {r_sq, 2'b00};
    assign w_oddsq = w_sq4 + WGT_W'({r_odd, 1'b0}) - WGT_W'(1);

    always_comb begin
        w2   = '0;
        w3   = '0;
        neg3 = c_neg ^ par;
        unique case (i_mode)
            MODE_FULL: begin
                w2   = w_sq;
                w3   = w_sq;
                neg3 = ~(c_neg ^ par);
            end
            MODE_COMPACT: w3 = w_sq;
            MODE_EVEN:    w2 = w_sq4;
            MODE_ODD: begin
                w2 = w_oddsq;
                w3 = WGT_W'(r_odd);
            end
            default: begin
                w2 = '0;
                w3 = '0;
            end
        endcase
    end

    assign term = r_prod[63:0];
    assign t2   = r_neg2 ? -term : term;
    assign t3   = r_neg3 ? -term : term;

    assign bsel   = r_bank[i_cmd.sel];
    assign bmag   = bsel[63] ? (~bsel + 64'd1) : bsel;
    assign ds_mag = i_deriv_scale[31] ? (~i_deriv_scale + 32'd1) : i_deriv_scale;

    always_comb begin
        unique case (i_cmd.limb)
            2'd0:    limb = r_ma[31:0];
            2'd1:    limb = r_ma[63:32];
            default: limb = r_ma[95:64];
        endcase
    end

    assign pp = 64'(limb) * 64'(r_mb);

    always_comb begin
        unique case (i_cmd.limb)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
    end

    // round to nearest, ties away from zero, on the magnitude
    assign rsum = r_prod + (i_cmd.sel[1] ? HALF_S : HALF_V);
    assign rq   = i_cmd.sel[1] ? (rsum >> (2 * FRAC_BITS)) : (rsum >> FRAC_BITS);
    assign big  = |rq[127:63];

    always_comb begin
        if (big) begin
            fin = r_negf ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            fin = r_negf ? -rq[63:0] : rq[63:0];
        end
    end

    assign zero = r_mode[2]
               || (i_cmd.sel == 2'd1 && r_mode == MODE_ODD)
               || (i_cmd.sel == 2'd2 && r_mode == MODE_COMPACT)
               || (i_cmd.sel == 2'd3 && r_mode == MODE_EVEN);

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sq        <= '0;
            r_odd       <= ODD_W'(1);
            r_bank[0]   <= '0;
            r_bank[1]   <= '0;
            r_bank[2]   <= '0;
            r_bank[3]   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (r_idx != IDX_LAST) begin
                    r_idx <= r_idx + IDX_W'(1);
                    r_sq  <= r_sq + SQ_W'(r_odd);
                    r_odd <= r_odd + ODD_W'(2);
                end
                if (!i_mode[2]) begin
                    r_bank[0] <= sat_add(r_bank[0], c64);
                    if (i_mode != MODE_ODD) begin
                        r_bank[1] <= sat_add(r_bank[1], sc);
                    end
                end
            end
            if (i_cmd.add2) begin
                r_bank[2] <= sat_add(r_bank[2], t2);
            end
            if (i_cmd.add3) begin
                r_bank[3] <= sat_add(r_bank[3], t3);
            end
            if (i_cmd.emit) begin
                r_idx       <= '0;
                r_sq        <= '0;
                r_odd       <= ODD_W'(1);
                r_bank[0]   <= '0;
                r_bank[1]   <= '0;
                r_bank[2]   <= '0;
                r_bank[3]   <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shared multiplier and payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.load)
            LD_ITEM: begin
                r_ma   <= {64'd0, c_mag};
                r_mb   <= 32'(w2);
                r_prod <= '0;
                r_neg2 <= c_neg;
                r_neg3 <= neg3;
                r_w3   <= w3;
                r_mode <= i_mode;
                r_last <= i_in_word.last;
            end
            LD_W3: begin
                r_mb   <= 32'(r_w3);
                r_prod <= '0;
            end
            LD_BANK: begin
                r_ma   <= {32'd0, bmag};
                r_mb   <= i_cmd.sel[1] ? ds_mag : INV_SQRT2_Q32;
                r_prod <= '0;
                r_negf <= bsel[63] ^ (i_cmd.sel[1] & i_deriv_scale[31]);
            end
            LD_PROD: begin
                r_ma   <= r_prod[95:0];
                r_mb   <= INV_SQRT2_Q32;
                r_prod <= '0;
            end
            default: begin
                if (i_cmd.step) begin
                    r_prod <= r_prod + pp_sh;
                end
            end
        endcase
        if (i_cmd.round) begin
            r_res[i_cmd.sel] <= zero ? 64'sd0 : fin;
        end
        if (i_cmd.emit) begin
            r_out.value_at_one   <= r_res[0];
            r_out.value_at_inner <= r_res[1];
            r_out.slope_at_one   <= r_res[2];
            r_out.slope_at_inner <= r_res[3];
            r_out.bad_mode       <= r_mode[2];
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out;

endmodule

// ===== sv/chebyshev_endpoint_evaluator_core.sv =====
`timescale 1ns / 1ps
// Chebyshev series endpoint evaluator.
// Input channel (i_in_valid/o_in_ready, i_in_data): one signed coefficient
// word per transfer, lowest index first, with last marking the final term.
// Output channel (o_out_valid/i_out_ready, o_out_data): one result word per
// series with value and slope at +1 and at the inner point, Q32.32,
// saturated, plus bad_mode.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 basis_mode, index 1
// deriv_scale; write only while the core is idle. Always ready.
// Input pacing: a new coefficient is taken only once the previous one is done;
// two products per term go through a single shared 32x32 multiplier.
// Finish: after the last coefficient is accepted, the final scaling runs the
// same multiplier limb by limb before the result word is made valid.
// Reset: synchronous, active low; clears accumulators, term index and output
// valid, and sets basis_mode to full and deriv_scale to 1.0.
// Stall: a pending result word holds while i_out_ready is low; new
// coefficients are taken meanwhile, and the next series stalls before its
// result is written only if the previous word is still waiting.
module chebyshev_endpoint_evaluator_core
    import cee_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [2:0]         r_basis_mode;
    logic signed [31:0] r_deriv_scale;
    t_dp_cmd            cmd;
    t_dp_sts            sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_mode  <= BASIS_MODE_RST;
            r_deriv_scale <= DERIV_SCALE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASIS_MODE:  r_basis_mode  <= i_cfg_data[2:0];
                CFG_DERIV_SCALE: r_deriv_scale <= i_cfg_data;
                default:         r_basis_mode  <= r_basis_mode;
            endcase
        end
    end

    cee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cee_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_word     (i_in_data),
        .i_mode        (r_basis_mode),
        .i_deriv_scale (r_deriv_scale),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_data)
    );

endmodule
